### src/fvcc_pkg.sv
// Shared types, constants and the color wheel table for the flow color coder.
// Used by fvcc_cordic, fvcc_divsqrt and flow_vector_color_coding_core.
package fvcc_pkg;

    localparam int WheelSize   = 55;
    localparam int TurnBits    = 24;
    localparam int CordicSteps = 18;
    localparam int CordicW     = 34;
    localparam int DivSteps    = 32;
    localparam int SqrtSteps   = 17;

    typedef logic [23:0] wheel_rom_t [WheelSize];
    typedef logic [23:0] atan_rom_t [CordicSteps];

    localparam atan_rom_t AtanTurn = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
        24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304,
        24'd652, 24'd326, 24'd163, 24'd81, 24'd41, 24'd20
    };

    // entry is {blue, green, red}
    function automatic wheel_rom_t build_wheel();
        wheel_rom_t rom;
        int i, r, g, b;
        for (int k = 0; k < WheelSize; k++) begin
            if (k < 15) begin
                i = k; r = 255; g = 255 * i / 15; b = 0;
            end else if (k < 21) begin
                i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
            end else if (k < 25) begin
                i = k - 21; r = 0; g = 255; b = 255 * i / 4;
            end else if (k < 36) begin
                i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
            end else if (k < 49) begin
                i = k - 36; r = 255 * i / 13; g = 0; b = 255;
            end else begin
                i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
            end
            rom[k] = {8'(b), 8'(g), 8'(r)};
        end
        return rom;
    endfunction

    localparam wheel_rom_t Wheel = build_wheel();

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAG, ST_RUN, ST_BLEND, ST_SCALE, ST_FIN, ST_OUT
    } seq_state_t;

endpackage

### src/flow_vector_color_coding_core.sv
// Flow color coder top: sequencer, magnitude range tracking and wheel blend.
// Instantiates fvcc_cordic and fvcc_divsqrt; depends on fvcc_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  s_      | s_tvalid / s_tready   | tdata {flow_y, flow_x}, tuser {unk, start, op}
//  m_      | m_tvalid / m_tready   | tdata {blue, green, red}
//
// Measure item: ST_MAG, then idle. Color item: ST_RUN, where fvcc_divsqrt does 32
// divide steps plus 17 square-root steps (CORDIC runs alongside), then ST_BLEND,
// ST_SCALE, ST_FIN per channel, then ST_OUT. Unknown color item: ST_MAG, ST_OUT.
// s_tready is high only in idle; a result waits in the output register until taken.
// Synchronous active-low reset clears control state and the stored maximum.
module flow_vector_color_coding_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] flow_x, [31:16] flow_y
    input  logic [2:0]  s_tuser,   // [0] operation, [1] frame_start, [2] flow_unknown
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
    import fvcc_pkg::*;

    seq_state_t state_reg, state_next;
    logic       cor_start, cor_done, ds_start, ds_done;

    logic signed [15:0] fx_reg, fy_reg;
    logic        op_reg, unk_reg;
    logic [31:0] magsq_reg, max_reg, big_reg;
    logic        over_reg;
    logic [5:0]  k0_reg;
    logic [15:0] f_reg;
    logic [1:0]  ch_reg;
    logic [24:0] blend_reg;
    logic [40:0] prod_reg;
    logic [7:0]  col_reg [3];
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    logic [23:0] turn;
    logic [16:0] radius;
    logic [29:0] fk;
    logic [7:0]  c0, c1;
    logic [5:0]  k1;
    logic [41:0] fin_norm;
    logic [7:0]  fin_val;
    logic        accept, out_free;
    logic [31:0] max_eff;
    logic signed [15:0] in_fx, in_fy;
    logic signed [31:0] sq_x, sq_y;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MAG;
            ST_MAG: begin
                if (!op_reg)      state_next = ST_IDLE;
                else if (unk_reg) state_next = ST_OUT;
                else              state_next = ST_RUN;
            end
            ST_RUN:   if (cor_done && ds_done) state_next = ST_BLEND;
            ST_BLEND: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_FIN;
            ST_FIN:   state_next = (ch_reg == 2'd2) ? ST_OUT : ST_BLEND;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cor_start = (state_reg == ST_MAG) && op_reg && !unk_reg;
        ds_start  = cor_start;
    end

    assign max_eff = (max_reg == '0) ? 32'h0001_0000 : max_reg;

    fvcc_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start),
        .fx(fx_reg), .fy(fy_reg), .done(cor_done), .turn(turn)
    );

    fvcc_divsqrt u_divsqrt (
        .aclk(aclk), .aresetn(aresetn), .start(ds_start),
        .mag_sq(magsq_reg), .big(max_eff), .done(ds_done), .radius(radius)
    );

    // squared magnitude of the incoming vector, registered at accept
    assign in_fx = s_tdata[15:0];
    assign in_fy = s_tdata[31:16];
    assign sq_x  = in_fx * in_fx;
    assign sq_y  = in_fy * in_fy;

    always_comb begin
        fk       = 30'(turn) * 30'(WheelSize - 1);
        k1       = k0_reg + 6'd1;
        c0       = Wheel[k0_reg][8*ch_reg +: 8];
        c1       = Wheel[k1][8*ch_reg +: 8];
        fin_norm = (42'd255 << 32) - 42'(prod_reg);
        fin_val  = over_reg ? prod_reg[25:18] : fin_norm[39:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
            ch_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (accept && s_tuser[1]) max_reg <= '0;
            if (state_reg == ST_MAG && !op_reg && !unk_reg && magsq_reg > max_reg)
                max_reg <= magsq_reg;
            if (m_tvalid && m_tready) m_valid_reg <= 1'b0;
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            if (state_reg == ST_RUN) ch_reg <= '0;
            if (state_reg == ST_FIN) ch_reg <= ch_reg + 2'd1;
        end
        if (accept) begin
            fx_reg    <= s_tdata[15:0];
            fy_reg    <= s_tdata[31:16];
            op_reg    <= s_tuser[0];
            unk_reg   <= s_tuser[2];
            magsq_reg <= 32'(sq_x) + 32'(sq_y);
        end
        if (state_reg == ST_MAG) begin
            big_reg <= max_eff;
            col_reg[0] <= '0; col_reg[1] <= '0; col_reg[2] <= '0;
        end
        if (state_reg == ST_MAG) over_reg <= 1'b0;
        if (state_reg == ST_RUN) begin
            over_reg <= magsq_reg > big_reg;
            k0_reg   <= fk[29:24];
            f_reg    <= fk[23:8];
        end
        if (state_reg == ST_BLEND)
            blend_reg <= 25'((17'h10000 - 17'(f_reg)) * 25'(c0)) + 25'(f_reg * 24'(c1));
        if (state_reg == ST_SCALE)
            prod_reg <= over_reg ? 41'(blend_reg) * 41'd3
                                 : 41'(radius) * 41'(25'd16711680 - blend_reg);
        if (state_reg == ST_FIN) col_reg[ch_reg] <= fin_val;
        if (state_reg == ST_OUT && out_free)
            m_data_reg <= {col_reg[2], col_reg[1], col_reg[0]};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

### src/fvcc_cordic.sv
// Iterative vectoring CORDIC: angle of (fx, fy) as a fraction of a turn.
// One add/subtract/shift step per cycle. Depends on fvcc_pkg.
module fvcc_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [15:0]   fx,
    input  logic signed [15:0]   fy,
    output logic                 done,
    output logic [23:0]          turn
);
    import fvcc_pkg::*;

    logic signed [CordicW-1:0] x_reg, x_next, y_reg, y_next;
    logic [23:0] z_reg, z_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic signed [CordicW-1:0] xs, ys, x0, y0;

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        x0 = CordicW'(fx) <<< 14;
        y0 = CordicW'(fy) <<< 14;
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (start) begin
            cnt_next = '0;
            if (fy == 16'sd0) begin
                busy_next = 1'b0;
                z_next = (fx < 0) ? 24'h800000 : 24'h0;
            end else begin
                busy_next = 1'b1;
                if (fx < 0) begin
                    x_next = -x0; y_next = -y0; z_next = 24'h800000;
                end else begin
                    x_next = x0; y_next = y0; z_next = 24'h0;
                end
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + AtanTurn[cnt_reg];
            end else begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - AtanTurn[cnt_reg];
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(CordicSteps - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = !busy_reg;
    assign turn = z_reg;
endmodule

### src/fvcc_divsqrt.sv
// Shift-subtract unit: radius r = isqrt(floor(m * 2^32 / big)), one bit per cycle,
// division then square root on the same compare/subtract path. Depends on fvcc_pkg.
module fvcc_divsqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] mag_sq,
    input  logic [31:0] big,
    output logic        done,
    output logic [16:0] radius
);
    import fvcc_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [33:0] res_reg, res_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        busy_reg, busy_next;
    logic [33:0] rem_sh, trial, bitv;

    always_comb begin
        rem_next = rem_reg; res_next = res_reg; cnt_next = cnt_reg;
        div_next = div_reg; busy_next = busy_reg;
        rem_sh = {rem_reg[32:0], 1'b0};
        bitv   = 34'd1 << {cnt_reg[4:0], 1'b0};
        trial  = res_reg + bitv;
        if (start) begin
            busy_next = 1'b1;
            if (mag_sq == big) begin
                div_next = 1'b0; rem_next = 34'h1_0000_0000;
                res_next = '0; cnt_next = 6'(SqrtSteps - 1);
            end else begin
                div_next = 1'b1; rem_next = 34'(mag_sq);
                res_next = '0; cnt_next = 6'(DivSteps - 1);
            end
        end else if (busy_reg && div_reg) begin
            if (rem_sh >= 34'(big)) begin
                rem_next = rem_sh - 34'(big);
                res_next = {res_reg[32:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                res_next = {res_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                div_next = 1'b0;
                rem_next = res_next;
                res_next = '0;
                cnt_next = 6'(SqrtSteps - 1);
            end
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bitv;
            end else begin
                res_next = res_reg >> 1;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done   = !busy_reg;
    assign radius = res_reg[16:0];
endmodule

### tb/flow_vector_color_coding_core_test.sv
// Testbench for flow_vector_color_coding_core: directed table, then random measure/color items,
// checked against an in-bench color wheel predictor. Depends on fvcc_pkg (WheelSize, TurnBits).
module flow_vector_color_coding_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fvcc_pkg::*;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_COLOR   = 1'b1;
    localparam int   WATCHDOG   = 20000;
    localparam int   DIRECTED_N = 16;
    localparam int   RANDOM_N   = 540;

    typedef struct {
        logic        op;
        logic        fs;
        logic [15:0] fx;
        logic [15:0] fy;
        logic        unk;
        logic        has_exp;
        logic [23:0] exp;
    } flow_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    flow_vector_color_coding_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [31:0] max_mag_sq;
    logic [23:0] color_q[$];
    flow_item_t  stim[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          send_done = 0;
    bit          long_hold = 0;

    function automatic logic [7:0] wheel_chan(int k, int ch);
        int i, r, g, b;
        if (k < 15) begin
            i = k; r = 255; g = 255 * i / 15; b = 0;
        end else if (k < 21) begin
            i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
        end else if (k < 25) begin
            i = k - 21; r = 0; g = 255; b = 255 * i / 4;
        end else if (k < 36) begin
            i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
        end else if (k < 49) begin
            i = k - 36; r = 255 * i / 13; g = 0; b = 255;
        end else begin
            i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
        end
        return ch == 0 ? r[7:0] : (ch == 1 ? g[7:0] : b[7:0]);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] vector_turn(logic signed [15:0] fx, logic signed [15:0] fy);
        longint signed x, y, z, nx, ny;
        longint signed atan[18] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
            41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};
        z = 0;
        if (fy == 0) return fx < 0 ? 24'h800000 : 24'h0;
        x = fx;
        y = fy;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd1 << (TurnBits - 1);
        end
        x = x * 16384;
        y = y * 16384;
        for (int i = 0; i < 18; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan[i];
            end
            x = nx; y = ny;
        end
        return z[23:0];
    endfunction

    // updates the stored maximum; returns 1 with the color when a result is due
    function automatic bit predict_color(flow_item_t it, output logic [23:0] rgb);
        logic signed [15:0] fx, fy;
        longint unsigned m, big, r, fk, f, blend, d, v;
        int k0, k1;
        fx = it.fx;
        fy = it.fy;
        m = longint'(fx) * fx + longint'(fy) * fy;
        r = 0;
        rgb = '0;
        if (it.fs) max_mag_sq = '0;
        if (it.op == OP_MEASURE) begin
            if (!it.unk && m > max_mag_sq) max_mag_sq = m[31:0];
            return 0;
        end
        if (it.unk) return 1;
        big = max_mag_sq != 0 ? max_mag_sq : 65536;
        if (m <= big) r = int_sqrt((m << 32) / big);
        fk = longint'(vector_turn(fx, fy)) * (WheelSize - 1);
        k0 = fk >> TurnBits;
        if (k0 > WheelSize - 1) k0 = WheelSize - 1;
        k1 = (k0 + 1) % WheelSize;
        f = (fk >> 8) & 64'hFFFF;
        for (int ch = 0; ch < 3; ch++) begin
            blend = (65536 - f) * wheel_chan(k0, ch) + f * wheel_chan(k1, ch);
            if (m <= big) begin
                d = 255 * 65536 - blend;
                v = ((64'd255 << 32) - r * d) >> 32;
            end else begin
                v = (blend * 3) >> 18;
            end
            rgb[ch*8 +: 8] = v[7:0];
        end
        return 1;
    endfunction

    function automatic flow_item_t mk(logic op, logic fs, logic [15:0] fx, logic [15:0] fy,
                                      logic unk, logic has_exp = 0, logic [23:0] exp = '0);
        flow_item_t it;
        it.op = op; it.fs = fs; it.fx = fx; it.fy = fy; it.unk = unk;
        it.has_exp = has_exp; it.exp = exp;
        return it;
    endfunction

    function automatic logic [15:0] rand_flow();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'h8000 + 16'($urandom_range(0, 3));
            2: return 16'h7FFF - 16'($urandom_range(0, 3));
            3: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($signed($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    initial begin
        flow_item_t directed[DIRECTED_N];
        flow_item_t it;
        directed = '{
            mk(OP_COLOR, 0, 16'h0000, 16'h0000, 0, 1, 24'hFFFFFF),
            mk(OP_COLOR, 0, 16'h1234, 16'h5678, 1, 1, 24'h000000),
            mk(OP_COLOR, 0, 16'h0100, 16'h0000, 0, 1, 24'h0000FF),
            mk(OP_COLOR, 0, 16'hFF00, 16'h0000, 0),
            mk(OP_COLOR, 0, 16'h0000, 16'h0100, 0),
            mk(OP_COLOR, 0, 16'h7FFF, 16'h7FFF, 0),
            mk(OP_MEASURE, 0, 16'h8000, 16'h8000, 0),
            mk(OP_MEASURE, 0, 16'h7FFF, 16'h7FFF, 1),
            mk(OP_COLOR, 0, 16'h8000, 16'h8000, 0),
            mk(OP_COLOR, 0, 16'h7FFF, 16'h8000, 0),
            mk(OP_COLOR, 0, 16'h0000, 16'h8000, 0),
            mk(OP_MEASURE, 1, 16'h0200, 16'hFE00, 0),
            mk(OP_COLOR, 0, 16'hFF00, 16'h0100, 0),
            mk(OP_COLOR, 0, 16'h0300, 16'h0000, 0),
            mk(OP_COLOR, 1, 16'h0080, 16'hFF80, 0),
            mk(OP_COLOR, 0, 16'h0000, 16'h0000, 1, 1, 24'h000000)
        };
        foreach (directed[i]) stim.insert(stim.size(), directed[i]);
        for (int n = 0; n < RANDOM_N; n++) begin
            it = mk($urandom_range(0, 2) != 0, $urandom_range(0, 15) == 0,
                    rand_flow(), rand_flow(), $urandom_range(0, 11) == 0);
            if ($urandom_range(0, 9) == 0) it.fy = '0;
            stim.insert(stim.size(), it);
        end
    end

    initial begin
        flow_item_t it;
        logic [23:0] rgb;
        int gap;
        max_mag_sq = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        while (stim.size() != 0) begin
            it = stim.pop_front();
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {it.fy, it.fx};
            s_tuser  <= {it.unk, it.fs, it.op};
            do @(posedge aclk); while (!s_tready);
            if (predict_color(it, rgb)) begin
                if (it.has_exp && rgb !== it.exp) begin
                    $display("%0t table entry differs from predictor: table %h predictor %h",
                             $time, it.exp, rgb);
                    errors++;
                end
                color_q.insert(color_q.size(), it.has_exp ? it.exp : rgb);
            end
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;
        send_done = 1;
    end

    initial begin
        int gap;
        int taken = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            if (taken == 40 && !long_hold) begin
                long_hold = 1;
                gap = 300;
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (color_q.size() == 0) begin
                $display("%0t unexpected item: expected none actual %h", $time, m_tdata);
                errors++;
            end else if (m_tdata !== color_q[0]) begin
                $display("%0t color mismatch: expected r%h g%h b%h actual r%h g%h b%h", $time,
                         color_q[0][7:0], color_q[0][15:8], color_q[0][23:16],
                         m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                errors++;
                void'(color_q.pop_front());
            end else begin
                void'(color_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("flow_vector_color_coding_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        wait (send_done);
        wait (color_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && color_q.size() == 0) begin
            $display("flow_vector_color_coding_core_test: PASS");
        end else begin
            $display("flow_vector_color_coding_core_test: FAIL");
        end
        $finish;
    end
endmodule
